[rtl/gbn_pkg.sv]
// Shared constants, types and state encodings of the Go-Back-N sender.
`default_nettype none
package gbn_pkg;

  localparam int WIN_DEPTH = 8;
  localparam int PTR_W = $clog2(WIN_DEPTH);
  localparam int CNT_W = $clog2(WIN_DEPTH + 1);
  localparam int SEQ_W = 32;
  localparam int DATA_W = 32;
  localparam int WSIZE_W = 4;

  localparam logic [SEQ_W-1:0] SEQ_RESET = 32'd1;
  localparam logic [WSIZE_W-1:0] WIN_RESET = 4'd4;

  localparam logic [1:0] REQ_SEND = 2'd0;
  localparam logic [1:0] REQ_ACK = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  localparam logic [1:0] TMR_NONE = 2'd0;
  localparam logic [1:0] TMR_START = 2'd1;
  localparam logic [1:0] TMR_STOP = 2'd2;
  localparam logic [1:0] TMR_RESTART = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ACK_DROP,
    ST_ACK_DONE,
    ST_RETX
  } state_t;

  typedef enum logic [2:0] {
    EM_NOOP,
    EM_SEND,
    EM_ACK,
    EM_TO_EMPTY,
    EM_RETX
  } emit_kind_t;

  typedef struct packed {
    logic       latch;
    logic       emit;
    emit_kind_t kind;
    logic       commit_send;
    logic       drop;
    logic       cnt_clr;
    logic       cnt_inc;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       full;
    logic       empty;
    logic       ack_ok;
    logic       drop_ok;
    logic       retx_last;
    logic       out_free;
  } status_t;

endpackage
`default_nettype wire

[rtl/gbn_dp.sv]
// Datapath of the Go-Back-N sender: window state, payload store and result register.
`default_nettype none
module gbn_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire gbn_pkg::cmd_t                 cmd,
  output gbn_pkg::status_t                   status,
  input  wire logic                          cfg_valid,
  input  wire logic [gbn_pkg::WSIZE_W-1:0]   cfg_data,
  input  wire logic [1:0]                    in_req_type,
  input  wire logic [gbn_pkg::DATA_W-1:0]    in_payload,
  input  wire logic [gbn_pkg::SEQ_W-1:0]     in_ack_num,
  input  wire logic                          in_ack_valid,
  input  wire logic [gbn_pkg::SEQ_W-1:0]     in_timeout_seq,
  input  wire logic                          out_tready,
  output logic                               out_valid,
  output logic                               out_accepted,
  output logic                               out_pkt_valid,
  output logic [gbn_pkg::SEQ_W-1:0]          out_pkt_seq,
  output logic [gbn_pkg::DATA_W-1:0]         out_pkt_data,
  output logic [1:0]                         out_timer_cmd,
  output logic [gbn_pkg::SEQ_W-1:0]          out_timer_seq,
  output logic                               out_window_full,
  output logic                               out_last
);
  import gbn_pkg::*;

  logic [WSIZE_W-1:0] window_size_r;
  logic [SEQ_W-1:0]   next_seq_r, next_seq_nxt;
  logic [SEQ_W-1:0]   oldest_seq_r, oldest_seq_nxt;
  logic [CNT_W-1:0]   in_flight_r, in_flight_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   cnt_r, cnt_nxt;

  logic [1:0]         req_r;
  logic [DATA_W-1:0]  payload_r;
  logic [SEQ_W-1:0]   ack_num_r;
  logic               ack_valid_r;
  logic [SEQ_W-1:0]   tmo_seq_r;

  logic [DATA_W-1:0]  store [WIN_DEPTH];
  logic [DATA_W-1:0]  rd_data_r;
  logic [PTR_W-1:0]   wr_addr;
  logic [PTR_W-1:0]   rd_addr;

  logic [CNT_W-1:0]   limit;
  logic               full;
  logic               empty;
  logic               ack_ge;
  logic               retx_last;
  logic               out_free;

  logic               out_valid_r, out_valid_nxt;
  logic               accepted_r, accepted_nxt;
  logic               pkt_valid_r, pkt_valid_nxt;
  logic [SEQ_W-1:0]   pkt_seq_r, pkt_seq_nxt;
  logic [DATA_W-1:0]  pkt_data_r, pkt_data_nxt;
  logic [1:0]         timer_cmd_r, timer_cmd_nxt;
  logic [SEQ_W-1:0]   timer_seq_r, timer_seq_nxt;
  logic               window_full_r, window_full_nxt;
  logic               last_r, last_nxt;

  assign limit = (window_size_r > WSIZE_W'(WIN_DEPTH)) ? CNT_W'(WIN_DEPTH)
                                                      : CNT_W'(window_size_r);
  assign full = in_flight_r >= limit;
  assign empty = in_flight_r == '0;
  assign ack_ge = ack_num_r >= oldest_seq_r;
  assign retx_last = (CNT_W'(cnt_r) + CNT_W'(1)) == in_flight_r;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    status.req = req_r;
    status.full = full;
    status.empty = empty;
    status.ack_ok = ack_valid_r && !empty && ack_ge;
    status.drop_ok = !empty && ack_ge;
    status.retx_last = retx_last;
    status.out_free = out_free;
  end

  always_comb begin
    next_seq_nxt = next_seq_r;
    oldest_seq_nxt = oldest_seq_r;
    in_flight_nxt = in_flight_r;
    head_nxt = head_r;
    if (cmd.commit_send) begin
      next_seq_nxt = next_seq_r + SEQ_W'(1);
      in_flight_nxt = in_flight_r + CNT_W'(1);
    end else if (cmd.drop) begin
      oldest_seq_nxt = oldest_seq_r + SEQ_W'(1);
      in_flight_nxt = in_flight_r - CNT_W'(1);
      head_nxt = head_r + PTR_W'(1);
    end
  end

  always_comb begin
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + PTR_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  assign wr_addr = head_r + in_flight_r[PTR_W-1:0];
  assign rd_addr = head_r + cnt_nxt;

  always_ff @(posedge clk) begin
    if (cmd.commit_send) begin
      store[wr_addr] <= payload_r;
    end
    rd_data_r <= store[rd_addr];
  end

  always_comb begin
    accepted_nxt = 1'b0;
    pkt_valid_nxt = 1'b0;
    pkt_seq_nxt = '0;
    pkt_data_nxt = '0;
    timer_cmd_nxt = TMR_NONE;
    timer_seq_nxt = '0;
    last_nxt = 1'b1;
    window_full_nxt = in_flight_nxt >= limit;
    case (cmd.kind)
      EM_SEND: begin
        if (!full) begin
          accepted_nxt = 1'b1;
          pkt_valid_nxt = 1'b1;
          pkt_seq_nxt = next_seq_r;
          pkt_data_nxt = payload_r;
          if (empty) begin
            timer_cmd_nxt = TMR_START;
            timer_seq_nxt = next_seq_r;
          end
        end
      end
      EM_ACK: begin
        if (empty) begin
          timer_cmd_nxt = TMR_STOP;
        end else begin
          timer_cmd_nxt = TMR_RESTART;
          timer_seq_nxt = oldest_seq_r;
        end
      end
      EM_TO_EMPTY: begin
        timer_cmd_nxt = TMR_RESTART;
        timer_seq_nxt = tmo_seq_r;
      end
      EM_RETX: begin
        pkt_valid_nxt = 1'b1;
        pkt_seq_nxt = oldest_seq_r + SEQ_W'(cnt_r);
        pkt_data_nxt = rd_data_r;
        last_nxt = retx_last;
        if (retx_last) begin
          timer_cmd_nxt = TMR_RESTART;
          timer_seq_nxt = tmo_seq_r;
        end
      end
      default: begin
        last_nxt = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WIN_RESET;
      next_seq_r <= SEQ_RESET;
      oldest_seq_r <= SEQ_RESET;
      in_flight_r <= '0;
      head_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        window_size_r <= cfg_data;
      end
      next_seq_r <= next_seq_nxt;
      oldest_seq_r <= oldest_seq_nxt;
      in_flight_r <= in_flight_nxt;
      head_r <= head_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_req_type;
      payload_r <= in_payload;
      ack_num_r <= in_ack_num;
      ack_valid_r <= in_ack_valid;
      tmo_seq_r <= in_timeout_seq;
    end
    if (cmd.emit) begin
      accepted_r <= accepted_nxt;
      pkt_valid_r <= pkt_valid_nxt;
      pkt_seq_r <= pkt_seq_nxt;
      pkt_data_r <= pkt_data_nxt;
      timer_cmd_r <= timer_cmd_nxt;
      timer_seq_r <= timer_seq_nxt;
      window_full_r <= window_full_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_accepted = accepted_r;
  assign out_pkt_valid = pkt_valid_r;
  assign out_pkt_seq = pkt_seq_r;
  assign out_pkt_data = pkt_data_r;
  assign out_timer_cmd = timer_cmd_r;
  assign out_timer_seq = timer_seq_r;
  assign out_window_full = window_full_r;
  assign out_last = last_r;

endmodule
`default_nettype wire

[rtl/gbn_ctrl.sv]
// Control state machine of the Go-Back-N sender.
`default_nettype none
module gbn_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire gbn_pkg::status_t status,
  output gbn_pkg::cmd_t         cmd
);
  import gbn_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.req == REQ_ACK && status.ack_ok) begin
          state_nxt = ST_ACK_DROP;
        end else if (status.req == REQ_TIMEOUT && !status.empty) begin
          state_nxt = ST_RETX;
        end else if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ACK_DROP: begin
        if (!status.drop_ok) begin
          state_nxt = ST_ACK_DONE;
        end
      end
      ST_ACK_DONE: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RETX: begin
        if (status.out_free && status.retx_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd = '0;
    cmd.kind = EM_NOOP;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
      end
      ST_EXEC: begin
        if (status.req == REQ_ACK && status.ack_ok) begin
          cmd.emit = 1'b0;
        end else if (status.req == REQ_TIMEOUT && !status.empty) begin
          cmd.cnt_clr = 1'b1;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.req == REQ_SEND) begin
            cmd.kind = EM_SEND;
            cmd.commit_send = !status.full;
          end else if (status.req == REQ_TIMEOUT) begin
            cmd.kind = EM_TO_EMPTY;
          end
        end
      end
      ST_ACK_DROP: begin
        cmd.drop = status.drop_ok;
      end
      ST_ACK_DONE: begin
        cmd.kind = EM_ACK;
        cmd.emit = status.out_free;
      end
      ST_RETX: begin
        cmd.kind = EM_RETX;
        cmd.emit = status.out_free;
        cmd.cnt_inc = status.out_free;
      end
      default: begin
        cmd.emit = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/go_back_n_sender.sv]
// Top level of the Go-Back-N sender: stream ports, controller and datapath.
// Each request is latched while idle and then worked on; the block takes
// a new request only after the previous one has placed its last result in the
// output register. A send, a refused ack or an unknown request is done in the
// execute state. An accepted ack first drops the acknowledged packets, as the
// window head advances one packet per cycle, and then emits its timer result.
// A timeout retransmits every packet in the window, one a cycle while the output
// is not stalled, from the payload store's registered read port.
// Write the window_size register via the cfg port only while idle; it is not enforced.
`default_nettype none
module go_back_n_sender (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [3:0]    cfg_data,    // window_size
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [103:0]  in_tdata,    // payload, ack_num, ack_valid, timeout_seq, zero pad
  input  wire logic [1:0]    in_tuser,    // req_type
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [103:0]       out_tdata,   // accepted, pkt_seq, pkt_data, timer_cmd,
                                          // timer_seq, window_full, zero pad
  output logic [0:0]         out_tuser,   // pkt_valid
  output logic               out_tlast    // last
);
  import gbn_pkg::*;

  cmd_t    cmd;
  status_t status;

  logic              accepted;
  logic              pkt_valid;
  logic [SEQ_W-1:0]  pkt_seq;
  logic [DATA_W-1:0] pkt_data;
  logic [1:0]        timer_cmd;
  logic [SEQ_W-1:0]  timer_seq;
  logic              window_full;

  assign cfg_ready = 1'b1;

  gbn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  gbn_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .in_req_type     (in_tuser),
    .in_payload      (in_tdata[31:0]),
    .in_ack_num      (in_tdata[63:32]),
    .in_ack_valid    (in_tdata[64]),
    .in_timeout_seq  (in_tdata[96:65]),
    .out_tready      (out_tready),
    .out_valid       (out_tvalid),
    .out_accepted    (accepted),
    .out_pkt_valid   (pkt_valid),
    .out_pkt_seq     (pkt_seq),
    .out_pkt_data    (pkt_data),
    .out_timer_cmd   (timer_cmd),
    .out_timer_seq   (timer_seq),
    .out_window_full (window_full),
    .out_last        (out_tlast)
  );

  assign out_tdata = {4'd0, window_full, timer_seq, timer_cmd, pkt_data, pkt_seq, accepted};
  assign out_tuser = pkt_valid;

`ifndef SYNTHESIS
  a_accept_has_pkt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && accepted |-> pkt_valid)
    else $error("accepted send result carries no packet");

  a_mid_result_retx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> pkt_valid && !accepted && timer_cmd == TMR_NONE)
    else $error("non-final result is not a plain retransmission");

  a_start_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && timer_cmd == TMR_START |-> accepted && timer_seq == pkt_seq)
    else $error("timer start not tagged with the sent packet");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new request taken while one is in progress");
`endif

endmodule
`default_nettype wire

[tb/go_back_n_checker.sv]
// Go-Back-N sender checker: watches the channels, predicts every result and compares.
`timescale 1ns / 100ps
module go_back_n_checker (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [3:0]            cfg_data,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [103:0]          in_tdata,
  input  wire logic [1:0]            in_tuser,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [103:0]          out_tdata,
  input  wire logic [0:0]            out_tuser,
  input  wire logic                  out_tlast,
  output int                         errors,
  output int                         pending,
  output int                         results_checked,
  output logic [gbn_pkg::SEQ_W-1:0]  seq_next,
  output logic [gbn_pkg::SEQ_W-1:0]  seq_oldest
);
  import gbn_pkg::*;

  typedef struct {
    logic              accepted;
    logic              pkt_valid;
    logic [SEQ_W-1:0]  pkt_seq;
    logic [DATA_W-1:0] pkt_data;
    logic [1:0]        timer_cmd;
    logic [SEQ_W-1:0]  timer_seq;
    logic              window_full;
    logic              last;
  } sender_result_t;

  sender_result_t    expected_tx[$];
  logic [WSIZE_W-1:0] win_size;
  logic [SEQ_W-1:0]  next_seq_m;
  logic [SEQ_W-1:0]  oldest_m;
  int unsigned       flight;
  int unsigned       head;
  logic [DATA_W-1:0] payload_mem[WIN_DEPTH];

  initial begin
    errors = 0;
    pending = 0;
    results_checked = 0;
    seq_next = SEQ_RESET;
    seq_oldest = SEQ_RESET;
  end

  function automatic int unsigned window_limit();
    return (win_size > WIN_DEPTH) ? WIN_DEPTH : int'(win_size);
  endfunction

  task automatic report(input string msg);
    if (errors < 40) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    errors++;
  endtask

  task automatic queue_result(input logic acc, input logic pv, input logic [SEQ_W-1:0] seq,
                              input logic [DATA_W-1:0] data, input logic [1:0] cmd,
                              input logic [SEQ_W-1:0] tseq, input logic fin);
    sender_result_t r;
    r.accepted = acc;
    r.pkt_valid = pv;
    r.pkt_seq = seq;
    r.pkt_data = data;
    r.timer_cmd = cmd;
    r.timer_seq = tseq;
    r.window_full = (flight >= window_limit());
    r.last = fin;
    expected_tx.push_back(r);
  endtask

  task automatic predict_window_step(input logic [1:0] req, input logic [DATA_W-1:0] payload,
                                     input logic [SEQ_W-1:0] ack_num, input logic ack_ok,
                                     input logic [SEQ_W-1:0] timeout_seq);
    logic [1:0]       cmd;
    logic [SEQ_W-1:0] seq;
    logic             fin;
    case (req)
      REQ_SEND: begin
        if (flight >= window_limit()) begin
          queue_result(1'b0, 1'b0, '0, '0, TMR_NONE, '0, 1'b1);
        end else begin
          cmd = (flight == 0) ? TMR_START : TMR_NONE;
          payload_mem[(head + flight) % WIN_DEPTH] = payload;
          flight++;
          seq = next_seq_m;
          next_seq_m = next_seq_m + 1'b1;
          queue_result(1'b1, 1'b1, seq, payload, cmd, (cmd == TMR_START) ? seq : '0, 1'b1);
        end
      end
      REQ_ACK: begin
        if (flight == 0 || !ack_ok || ack_num < oldest_m) begin
          queue_result(1'b0, 1'b0, '0, '0, TMR_NONE, '0, 1'b1);
        end else begin
          while (flight > 0 && ack_num >= oldest_m) begin
            oldest_m = oldest_m + 1'b1;
            head = (head + 1) % WIN_DEPTH;
            flight--;
          end
          if (flight > 0) begin
            queue_result(1'b0, 1'b0, '0, '0, TMR_RESTART, oldest_m, 1'b1);
          end else begin
            queue_result(1'b0, 1'b0, '0, '0, TMR_STOP, '0, 1'b1);
          end
        end
      end
      REQ_TIMEOUT: begin
        if (flight == 0) begin
          queue_result(1'b0, 1'b0, '0, '0, TMR_RESTART, timeout_seq, 1'b1);
        end else begin
          for (int unsigned i = 0; i < flight; i++) begin
            fin = (i + 1 == flight);
            queue_result(1'b0, 1'b1, oldest_m + i, payload_mem[(head + i) % WIN_DEPTH],
                         fin ? TMR_RESTART : TMR_NONE, fin ? timeout_seq : '0, fin);
          end
        end
      end
      default: begin
        queue_result(1'b0, 1'b0, '0, '0, TMR_NONE, '0, 1'b1);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report($sformatf("result %0d field %s: got %0h, expected %0h",
                       results_checked, name, got, want));
    end
  endtask

  task automatic check_result();
    sender_result_t want;
    if (expected_tx.size() == 0) begin
      report($sformatf("result transfer with nothing expected, data %0h", out_tdata));
    end else begin
      want = expected_tx.pop_front();
      // Result word from bit 0: accepted, pkt_seq, pkt_data, timer_cmd, timer_seq, window_full.
      check_field("accepted", out_tdata[0], want.accepted);
      check_field("pkt_valid", out_tuser[0], want.pkt_valid);
      check_field("pkt_seq", out_tdata[32:1], want.pkt_seq);
      check_field("pkt_data", out_tdata[64:33], want.pkt_data);
      check_field("timer_cmd", out_tdata[66:65], want.timer_cmd);
      check_field("timer_seq", out_tdata[98:67], want.timer_seq);
      check_field("window_full", out_tdata[99], want.window_full);
      check_field("last", out_tlast, want.last);
    end
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_tx.delete();
      win_size = WIN_RESET;
      next_seq_m = SEQ_RESET;
      oldest_m = SEQ_RESET;
      flight = 0;
      head = 0;
      foreach (payload_mem[i]) payload_mem[i] = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        win_size = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        predict_window_step(in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[64],
                            in_tdata[96:65]);
      end
      if (out_tvalid && out_tready) begin
        check_result();
      end
    end
    pending <= expected_tx.size();
    seq_next <= next_seq_m;
    seq_oldest <= oldest_m;
  end

endmodule

[tb/tb_top.sv]
// Testbench top of the Go-Back-N sender: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
  import gbn_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SEG_ITEMS = 36;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [3:0]   cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;    // payload, ack_num, ack_valid, timeout_seq, zero pad
  logic [1:0]   in_tuser = '0;    // req_type
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;        // accepted, pkt_seq, pkt_data, timer_cmd, timer_seq,
                                  // window_full, zero pad
  logic [0:0]   out_tuser;        // pkt_valid
  logic         out_tlast;

  int               errors;
  int               pending;
  int               results_checked;
  logic [SEQ_W-1:0] seq_next;
  logic [SEQ_W-1:0] seq_oldest;

  int unsigned send_idle_pct = 23;
  int unsigned recv_idle_pct = 61;
  int unsigned cycles = 0;
  int          n_send = 0;
  int          n_ack = 0;
  int          n_timeout = 0;
  int          n_other = 0;

  go_back_n_sender dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  go_back_n_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .errors          (errors),
    .pending         (pending),
    .results_checked (results_checked),
    .seq_next        (seq_next),
    .seq_oldest      (seq_oldest)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One request transfer; tvalid stays high into the next request unless a gap is drawn.
  task automatic put_request(input logic [1:0] req, input logic [31:0] payload,
                             input logic [31:0] ack_num, input logic ack_ok,
                             input logic [31:0] timeout_seq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {7'd0, timeout_seq, ack_ok, ack_num, payload};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (req)
      REQ_SEND: n_send++;
      REQ_ACK: n_ack++;
      REQ_TIMEOUT: n_timeout++;
      default: n_other++;
    endcase
  endtask

  task automatic wait_window_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_window_size(input logic [3:0] size);
    cfg_valid <= 1'b1;
    cfg_data <= size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly sends, acks near the live window and timeouts on the oldest packet,
  // with some fully random requests mixed in.
  task automatic random_request();
    int unsigned pick;
    logic [31:0] span;
    logic [31:0] ack_num;
    logic [31:0] tseq;
    pick = $urandom_range(99);
    span = seq_next - seq_oldest + 32'd1;
    ack_num = seq_oldest - 32'd1 + $urandom_range(span);
    tseq = ($urandom_range(99) < 70) ? seq_oldest : $urandom;
    if (pick < 48) begin
      put_request(REQ_SEND, $urandom, $urandom, 1'($urandom_range(1)), $urandom);
    end else if (pick < 73) begin
      put_request(REQ_ACK, $urandom, ack_num, ($urandom_range(99) < 85), $urandom);
    end else if (pick < 85) begin
      put_request(REQ_TIMEOUT, $urandom, $urandom, 1'($urandom_range(1)), tseq);
    end else begin
      put_request(2'($urandom_range(3)), $urandom, $urandom, 1'($urandom_range(1)), $urandom);
    end
  endtask

  initial begin
    logic [3:0] win_plan[7];
    win_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd8, 4'($urandom_range(1, 8))};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset window size of four.
    put_request(REQ_TIMEOUT, '0, '0, 1'b0, 32'hFFFF_FFFF);
    put_request(REQ_ACK, '0, 32'hFFFF_FFFF, 1'b1, '0);
    put_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    put_request(REQ_SEND, 32'h0000_0000, '0, 1'b0, '0);
    put_request(REQ_SEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    put_request(REQ_SEND, 32'hA5A5_5A5A, '0, 1'b0, '0);
    put_request(REQ_SEND, 32'h1234_5678, '0, 1'b0, '0);
    put_request(REQ_SEND, 32'hDEAD_BEEF, '0, 1'b0, '0);
    put_request(REQ_ACK, '0, 32'hFFFF_FFFF, 1'b0, '0);
    put_request(REQ_ACK, '0, 32'd0, 1'b1, '0);
    put_request(REQ_TIMEOUT, '0, '0, 1'b0, 32'd0);
    put_request(REQ_ACK, '0, 32'd2, 1'b1, '0);
    put_request(REQ_TIMEOUT, '0, '0, 1'b0, 32'd3);
    put_request(REQ_ACK, '0, 32'd3, 1'b1, '0);
    put_request(REQ_ACK, '0, 32'hFFFF_FFFF, 1'b1, '0);
    put_request(REQ_SEND, 32'h8000_0001, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    put_request(REQ_ACK, '0, 32'd6, 1'b1, '0);

    for (int seg = 0; seg < 7; seg++) begin
      wait_window_drained();
      if (seg >= 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (seg >= 2) begin
        send_idle_pct = 61;
        recv_idle_pct = 23;
      end
      write_window_size(win_plan[seg]);
      repeat (SEG_ITEMS) random_request();
    end

    wait_window_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d requests: %0d sends, %0d acks, %0d timeouts, %0d others; %0d results.",
             n_send + n_ack + n_timeout + n_other, n_send, n_ack, n_timeout, n_other,
             results_checked);
    $display("Window sizes 4, 1, 8, 0, 15, 3, 8 and %0d, under three stall profiles.",
             win_plan[6]);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/gbn_pkg.sv
rtl/gbn_dp.sv
rtl/gbn_ctrl.sv
rtl/go_back_n_sender.sv
tb/go_back_n_checker.sv
tb/tb_top.sv
